FILE: src/obs_pkg.sv
// Package for the oversampled box scaler: constants, types and the
// reciprocal table for the final average. No dependencies.
`default_nettype none
package obs_pkg;
    localparam int MAX_WIDTH_D  = 256;
    localparam int MAX_HEIGHT_D = 256;
    localparam int FRAC_BITS_D  = 16;
    localparam int OVER_MAX     = 8;
    localparam int CFG_W        = 25;
    localparam int CFG_IDX_W    = 3;

    typedef enum logic [2:0] {
        REG_SRC_WIDTH  = 3'd0,
        REG_SRC_HEIGHT = 3'd1,
        REG_STEP_X     = 3'd2,
        REG_STEP_Y     = 3'd3,
        REG_SUB_X      = 3'd4,
        REG_SUB_Y      = 3'd5,
        REG_OVER       = 3'd6
    } reg_idx_t;

    typedef enum logic [0:0] {
        CMD_LOAD   = 1'b0,
        CMD_RENDER = 1'b1
    } cmd_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_BASE,
        ST_READ,
        ST_DRAIN,
        ST_DIV,
        ST_OUT
    } state_t;

    // Sums reach at most 64*255 = 16320 (14 bits). Divide by n*n through
    // a 19-bit reciprocal ceil(2^18 / d); exact for x < 2^14 when d <= 64.
    function automatic logic [18:0] recip(input logic [3:0] n);
        case (n)
            4'd1:    recip = 19'd262144;
            4'd2:    recip = 19'd65536;
            4'd3:    recip = 19'd29128;
            4'd4:    recip = 19'd16384;
            4'd5:    recip = 19'd10486;
            4'd6:    recip = 19'd7282;
            4'd7:    recip = 19'd5350;
            4'd8:    recip = 19'd4096;
            default: recip = 19'd262144;
        endcase
    endfunction
endpackage
`default_nettype wire

FILE: src/obs_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
`default_nettype none
module obs_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 65536
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

FILE: src/oversampled_box_scaler.sv
// Oversampled box scaler top level: stream input, sequencer, image store
// and averaging. Depends on obs_pkg and obs_ram.
`default_nettype none
// Usage:
//   s_ words carry a command: a load writes one RGB pixel into the image
//   store (no result); a render returns one averaged RGB pixel on m_.
//   Configure through cfg_we/cfg_index/cfg_data only while idle.
// Sequence:
//   A load is taken in the idle state. A render steps through the base,
//   read, drain, divide and output states: the image store has a single
//   read port, so samples are fetched one per cycle, then the three sums
//   are scaled by a reciprocal multiply and registered.
//   Positions are formed as offset * step with one multiplier per axis in
//   the base state, then sample positions advance by adding sub-steps.
// Reset:
//   aresetn (synchronous, active low) restores the register defaults and
//   returns the sequencer to idle. The image store is not cleared; read
//   only pixels that were loaded.
// Stall:
//   The result is held in an output register until m_tready; the next
//   word is accepted once the result is taken.
module oversampled_box_scaler #(
    parameter int MAX_WIDTH  = obs_pkg::MAX_WIDTH_D,
    parameter int MAX_HEIGHT = obs_pkg::MAX_HEIGHT_D,
    parameter int FRAC_BITS  = obs_pkg::FRAC_BITS_D
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         s_tvalid,
    output logic                              s_tready,
    // fields from bit 0: pos_x[11:0], pos_y[11:0], in_red, in_green, in_blue
    input  wire logic [47:0]                  s_tdata,
    // fields: command
    input  wire logic                         s_tuser,
    output logic                              m_tvalid,
    input  wire logic                         m_tready,
    // fields from bit 0: out_red, out_green, out_blue
    output logic      [23:0]                  m_tdata,
    input  wire logic                         cfg_we,
    input  wire logic [obs_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [obs_pkg::CFG_W-1:0]     cfg_data
);
    import obs_pkg::*;

    localparam int XW = $clog2(MAX_WIDTH);
    localparam int YW = $clog2(MAX_HEIGHT);
    localparam int AW = XW + YW;
    localparam int PW = 12 + CFG_W + 3; // position accumulator width

    // configuration
    logic [8:0]       src_w_reg, src_h_reg;
    logic [CFG_W-1:0] step_x_reg, step_y_reg, sub_x_reg, sub_y_reg;
    logic [3:0]       over_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            src_w_reg  <= 9'd256;
            src_h_reg  <= 9'd256;
            step_x_reg <= CFG_W'(65536);
            step_y_reg <= CFG_W'(65536);
            sub_x_reg  <= CFG_W'(16384);
            sub_y_reg  <= CFG_W'(16384);
            over_reg   <= 4'd4;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_SRC_WIDTH:  src_w_reg  <= cfg_data[8:0];
                REG_SRC_HEIGHT: src_h_reg  <= cfg_data[8:0];
                REG_STEP_X:     step_x_reg <= cfg_data;
                REG_STEP_Y:     step_y_reg <= cfg_data;
                REG_SUB_X:      sub_x_reg  <= cfg_data;
                REG_SUB_Y:      sub_y_reg  <= cfg_data;
                REG_OVER:       over_reg   <= cfg_data[3:0];
                default:        ;
            endcase
        end
    end

    // effective limits
    logic [12:0] lim_w, lim_h;
    logic [3:0]  n_eff;
    always_comb begin
        if (src_w_reg == 9'd0)                   lim_w = 13'd1;
        else if ({4'd0, src_w_reg} > 13'(MAX_WIDTH)) lim_w = 13'(MAX_WIDTH);
        else                                     lim_w = {4'd0, src_w_reg};
        if (src_h_reg == 9'd0)                   lim_h = 13'd1;
        else if ({4'd0, src_h_reg} > 13'(MAX_HEIGHT)) lim_h = 13'(MAX_HEIGHT);
        else                                     lim_h = {4'd0, src_h_reg};
        if (over_reg == 4'd0)        n_eff = 4'd1;
        else if (over_reg > 4'd8)    n_eff = 4'd8;
        else                         n_eff = over_reg;
    end

    // sequencer state
    state_t          state_reg, state_next;
    logic [11:0]     px_reg, py_reg;
    logic [PW-1:0]   bx_reg, fx_reg, fy_reg;
    logic [2:0]      jx_reg, jy_reg;
    logic            rd_vld_reg;
    logic [13:0]     sr_reg, sg_reg, sb_reg;
    logic [32:0]     pr_reg, pg_reg, pb_reg;

    logic [23:0]   rdata;
    logic [AW-1:0] raddr, waddr;
    logic          we;
    logic [12:0]   col, row;

    // full-width base products offset * step
    logic [12+CFG_W-1:0] base_x, base_y;
    assign base_x = px_reg * step_x_reg;
    assign base_y = py_reg * step_y_reg;

    // truncate and clamp sample coordinates
    always_comb begin
        logic [PW-FRAC_BITS-1:0] ix, iy;
        ix = fx_reg[PW-1:FRAC_BITS];
        iy = fy_reg[PW-1:FRAC_BITS];
        if (ix >= (PW-FRAC_BITS)'(lim_w)) col = lim_w - 13'd1;
        else                              col = 13'(ix);
        if (iy >= (PW-FRAC_BITS)'(lim_h)) row = lim_h - 13'd1;
        else                              row = 13'(iy);
    end

    assign raddr = {row[YW-1:0], col[XW-1:0]};
    assign waddr = {s_tdata[12 +: YW], s_tdata[0 +: XW]};
    assign we    = s_tvalid && s_tready && (s_tuser == CMD_LOAD)
                   && ({1'b0, s_tdata[11:0]} < 13'(MAX_WIDTH))
                   && ({1'b0, s_tdata[23:12]} < 13'(MAX_HEIGHT));

    obs_ram #(.WIDTH(24), .DEPTH(1 << AW)) u_image (
        .aclk  (aclk),
        .we    (we),
        .waddr (waddr),
        .wdata (s_tdata[47:24]),
        .raddr (raddr),
        .rdata (rdata)
    );

    logic last_sample;
    assign last_sample = ({1'b0, jx_reg} == n_eff - 4'd1)
                         && ({1'b0, jy_reg} == n_eff - 4'd1);

    always_comb begin
        state_next = state_reg;
        s_tready   = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid && s_tuser == CMD_RENDER) state_next = ST_BASE;
            end
            ST_BASE:  state_next = ST_READ;
            ST_READ:  if (last_sample) state_next = ST_DRAIN;
            ST_DRAIN: state_next = ST_DIV;
            ST_DIV:   state_next = ST_OUT;
            ST_OUT:   if (m_tready) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            rd_vld_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            rd_vld_reg <= (state_reg == ST_READ);
        end
    end

    always_ff @(posedge aclk) begin
        logic [18:0] rc;
        rc = recip(n_eff);
        case (state_reg)
            ST_IDLE: begin
                px_reg <= s_tdata[11:0];
                py_reg <= s_tdata[23:12];
                sr_reg <= '0;
                sg_reg <= '0;
                sb_reg <= '0;
            end
            ST_BASE: begin
                // base positions offset * step
                bx_reg <= PW'(base_x);
                fx_reg <= PW'(base_x);
                fy_reg <= PW'(base_y);
                jx_reg <= '0;
                jy_reg <= '0;
            end
            ST_READ: begin
                // advance across the row, then down
                if ({1'b0, jx_reg} == n_eff - 4'd1) begin
                    jx_reg <= '0;
                    jy_reg <= jy_reg + 3'd1;
                    fx_reg <= bx_reg;
                    fy_reg <= fy_reg + PW'(sub_y_reg);
                end else begin
                    jx_reg <= jx_reg + 3'd1;
                    fx_reg <= fx_reg + PW'(sub_x_reg);
                end
            end
            ST_DIV: begin
                pr_reg <= sr_reg * rc;
                pg_reg <= sg_reg * rc;
                pb_reg <= sb_reg * rc;
            end
            default: ;
        endcase
        if (rd_vld_reg) begin
            sr_reg <= sr_reg + 14'(rdata[7:0]);
            sg_reg <= sg_reg + 14'(rdata[15:8]);
            sb_reg <= sb_reg + 14'(rdata[23:16]);
        end
    end

    assign m_tvalid = (state_reg == ST_OUT);
    assign m_tdata  = {pb_reg[25:18], pg_reg[25:18], pr_reg[25:18]};
endmodule
`default_nettype wire
